@@ rtl/core/validated_temperature_statistics_core_macros.svh @@
// Assertion macros shared by the checker of the temperature statistics core
`ifndef VALIDATED_TEMPERATURE_STATISTICS_CORE_MACROS_SVH
`define VALIDATED_TEMPERATURE_STATISTICS_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define VTSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vtsc assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define VTSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vtsc assertion failed");

`endif

@@ rtl/core/vtsc_pkg.sv @@
// Types, constants and helpers of the temperature statistics core
package vtsc_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int MONTH_SLOTS = 12;
  localparam int MIDX_W      = $clog2(MONTH_SLOTS);
  localparam int SUM_W       = COUNT_BITS + 8;
  localparam int MAG_W       = SUM_W - 1;
  localparam int Q_W         = 15;
  localparam int NUM_W       = MAG_W + 8;
  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int HOUR_W      = 5;
  localparam int MINUTE_W    = 6;
  localparam int TEMP_W      = 8;
  localparam int ERR_W       = 3;
  localparam int MEAN_W      = 16;
  localparam int TOTAL_W     = 20;
  localparam int MOD_W       = 9;
  localparam int STEP_W      = $clog2((Q_W > YEAR_W) ? Q_W : YEAR_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [YEAR_W-1:0]   YEAR_MIN   = YEAR_W'(1000);
  localparam logic [YEAR_W-1:0]   YEAR_MAX   = YEAR_W'(9999);
  localparam logic [MOD_W:0]      LEAP_CYCLE = (MOD_W + 1)'(400);
  localparam logic [MOD_W-1:0]    CENT_0     = MOD_W'(0);
  localparam logic [MOD_W-1:0]    CENT_1     = MOD_W'(100);
  localparam logic [MOD_W-1:0]    CENT_2     = MOD_W'(200);
  localparam logic [MOD_W-1:0]    CENT_3     = MOD_W'(300);
  localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -TEMP_W'(99);
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = TEMP_W'(99);
  localparam logic signed [TEMP_W-1:0] LOW_INIT  = TEMP_W'(100);
  localparam logic signed [TEMP_W-1:0] HIGH_INIT = -TEMP_W'(100);

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);

  typedef enum logic [ERR_W-1:0] {
    ERR_OK     = 3'd0,
    ERR_YEAR   = 3'd1,
    ERR_MONTH  = 3'd2,
    ERR_DAY    = 3'd3,
    ERR_HOUR   = 3'd4,
    ERR_MINUTE = 3'd5,
    ERR_TEMP   = 3'd6
  } err_e;

  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] d;
    if (m == MONTH_FEB) begin
      d = leap ? DAY_W'(29) : DAY_W'(28);
    end else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      d = DAY_W'(30);
    end else begin
      d = DAY_W'(31);
    end
    return d;
  endfunction

  function automatic logic [TOTAL_W-1:0] to_total(logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[TOTAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/vtsc_in_if.sv @@
// Reading channel: valid, ready and the timestamped temperature
interface vtsc_in_if;
  import vtsc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [YEAR_W-1:0]          year_in;
  logic [MONTH_W-1:0]         month_in;
  logic [DAY_W-1:0]           day_in;
  logic [HOUR_W-1:0]          hour_in;
  logic [MINUTE_W-1:0]        minute_in;
  logic signed [TEMP_W-1:0]   temp_in;

  modport source (output valid, year_in, month_in, day_in, hour_in, minute_in, temp_in,
                  input ready);
  modport sink   (input valid, year_in, month_in, day_in, hour_in, minute_in, temp_in,
                  output ready);
endinterface

@@ rtl/core/vtsc_out_if.sv @@
// Result channel: valid, ready, validity, error code and statistics
interface vtsc_out_if;
  import vtsc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [ERR_W-1:0]           error_code;
  logic signed [MEAN_W-1:0]   month_mean;
  logic signed [TEMP_W-1:0]   month_min;
  logic signed [TEMP_W-1:0]   month_max;
  logic [TOTAL_W-1:0]         month_total;
  logic signed [MEAN_W-1:0]   year_mean;
  logic signed [TEMP_W-1:0]   year_min;
  logic signed [TEMP_W-1:0]   year_max;
  logic [TOTAL_W-1:0]         year_total;

  modport source (output valid, accepted, error_code, month_mean, month_min, month_max,
                  month_total, year_mean, year_min, year_max, year_total,
                  input ready);
  modport sink   (input valid, accepted, error_code, month_mean, month_min, month_max,
                  month_total, year_mean, year_min, year_max, year_total,
                  output ready);
endinterface

@@ rtl/core/validated_temperature_statistics_core.sv @@
// Temperature statistics core: validate readings, keep month and overall min/max/mean
// Flow: the year is reduced mod 400 one bit a cycle, then each mean is computed by a shared
// bit-serial divider, first the month mean and then the overall mean.
// One reading at a time: ready only when idle; the next transaction is taken while a result waits.
// Reset: asynchronous, active low; all stores empty, sums and counts zero, min 100, max -100.
module validated_temperature_statistics_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  vtsc_in_if.sink   in_i,
  vtsc_out_if.source out_o
);
  import vtsc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_MEAN  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic              phase_q;
  logic              out_valid_q;

  logic [YEAR_W-1:0]        year_q, yr_sh_q;
  logic [MONTH_W-1:0]       month_q;
  logic [DAY_W-1:0]         day_q;
  logic [HOUR_W-1:0]        hour_q;
  logic [MINUTE_W-1:0]      minute_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [MOD_W-1:0]         rmd_q;
  err_e                     err_q;

  logic signed [SUM_W-1:0]  m_sum_q  [MONTH_SLOTS];
  logic [COUNT_BITS-1:0]    m_cnt_q  [MONTH_SLOTS];
  logic signed [TEMP_W-1:0] m_low_q  [MONTH_SLOTS];
  logic signed [TEMP_W-1:0] m_high_q [MONTH_SLOTS];
  logic signed [SUM_W-1:0]  a_sum_q;
  logic [COUNT_BITS-1:0]    a_cnt_q;
  logic signed [TEMP_W-1:0] a_low_q, a_high_q;

  logic [COUNT_BITS-1:0]    den_q, rem_q;
  logic [Q_W-1:0]           num_q, quo_q;
  logic                     neg_q;
  logic [COUNT_BITS-1:0]    s_cnt_q;
  logic signed [TEMP_W-1:0] s_low_q, s_high_q;
  logic [COUNT_BITS-1:0]    mcnt_q;
  logic signed [TEMP_W-1:0] mlo_q, mhi_q;
  logic signed [MEAN_W-1:0] mm_q, ym_q;

  logic                     accepted_q;
  logic [ERR_W-1:0]         error_code_q;
  logic signed [MEAN_W-1:0] o_mm_q, o_ym_q;
  logic signed [TEMP_W-1:0] o_mlo_q, o_mhi_q, o_ylo_q, o_yhi_q;
  logic [TOTAL_W-1:0]       o_mtot_q, o_ytot_q;

  logic                     in_take, out_load;
  logic [MOD_W:0]           mod_t;
  logic [MOD_W-1:0]         rmd_d;
  logic [MIDX_W-1:0]        midx;
  logic                     month_ok, leap;
  err_e                     err_c;
  logic signed [SUM_W-1:0]  temp_ext;

  logic signed [SUM_W-1:0]  sel_sum;
  logic [COUNT_BITS-1:0]    sel_cnt;
  logic signed [TEMP_W-1:0] sel_low, sel_high;
  logic [SUM_W-1:0]         sel_abs;
  logic [NUM_W-1:0]         numer;

  logic [COUNT_BITS:0]      div_t, div_diff;
  logic                     div_ge;
  logic [MEAN_W-1:0]        quo_ext;
  logic signed [MEAN_W-1:0] mean_c;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_take    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // year mod 400, one bit a cycle
  assign mod_t = {rmd_q, yr_sh_q[YEAR_W-1]};
  assign rmd_d = (mod_t >= LEAP_CYCLE) ? MOD_W'(mod_t - LEAP_CYCLE) : mod_t[MOD_W-1:0];

  assign month_ok = (month_q != '0) && (month_q <= MONTH_W'(MONTH_SLOTS));
  assign midx     = MIDX_W'(month_q - MONTH_W'(1));
  assign leap     = (year_q[1:0] == 2'b00)
                    && (!(rmd_q inside {CENT_0, CENT_1, CENT_2, CENT_3}) || (rmd_q == CENT_0));
  assign temp_ext = {{(SUM_W - TEMP_W){temp_q[TEMP_W-1]}}, temp_q};

  always_comb begin
    if ((year_q < YEAR_MIN) || (year_q > YEAR_MAX)) begin
      err_c = ERR_YEAR;
    end else if (!month_ok) begin
      err_c = ERR_MONTH;
    end else if ((day_q == '0) || (day_q > month_days(month_q, leap))) begin
      err_c = ERR_DAY;
    end else if (hour_q > HOUR_MAX) begin
      err_c = ERR_HOUR;
    end else if (minute_q > MINUTE_MAX) begin
      err_c = ERR_MINUTE;
    end else if ((temp_q < TEMP_MIN) || (temp_q > TEMP_MAX)) begin
      err_c = ERR_TEMP;
    end else begin
      err_c = ERR_OK;
    end
  end

  always_comb begin
    if (phase_q) begin
      sel_sum  = a_sum_q;
      sel_cnt  = a_cnt_q;
      sel_low  = a_low_q;
      sel_high = a_high_q;
    end else if (month_ok) begin
      sel_sum  = m_sum_q[midx];
      sel_cnt  = m_cnt_q[midx];
      sel_low  = m_low_q[midx];
      sel_high = m_high_q[midx];
    end else begin
      sel_sum  = '0;
      sel_cnt  = '0;
      sel_low  = '0;
      sel_high = '0;
    end
  end

  assign sel_abs = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  assign numer   = {sel_abs[MAG_W-1:0], 8'b0} + NUM_W'(sel_cnt >> 1);

  // restoring division, one quotient bit a cycle
  assign div_t    = {rem_q, num_q[Q_W-1]};
  assign div_ge   = (div_t >= {1'b0, den_q});
  assign div_diff = div_t - {1'b0, den_q};

  assign quo_ext = {{(MEAN_W - Q_W){1'b0}}, quo_q};
  assign mean_c  = (s_cnt_q == '0) ? '0 : (neg_q ? MEAN_W'(-quo_ext) : MEAN_W'(quo_ext));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_take) state_d = S_MOD;
      S_MOD:   if (step_q == STEP_W'(YEAR_W - 1)) state_d = S_CHECK;
      S_CHECK: state_d = S_LOAD;
      S_LOAD:  state_d = S_DIV;
      S_DIV:   if (step_q == STEP_W'(Q_W - 1)) state_d = S_MEAN;
      S_MEAN:  state_d = phase_q ? S_FIN : S_LOAD;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      a_sum_q     <= '0;
      a_cnt_q     <= '0;
      a_low_q     <= LOW_INIT;
      a_high_q    <= HIGH_INIT;
      for (int i = 0; i < MONTH_SLOTS; i++) begin
        m_sum_q[i]  <= '0;
        m_cnt_q[i]  <= '0;
        m_low_q[i]  <= LOW_INIT;
        m_high_q[i] <= HIGH_INIT;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          step_q  <= '0;
          phase_q <= 1'b0;
        end
        S_MOD:  step_q <= step_q + STEP_W'(1);
        S_LOAD: step_q <= '0;
        S_DIV:  step_q <= step_q + STEP_W'(1);
        S_MEAN: phase_q <= 1'b1;
        S_CHECK: begin
          if (err_c == ERR_OK) begin
            if (m_cnt_q[midx] != COUNT_MAX) begin
              m_sum_q[midx] <= m_sum_q[midx] + temp_ext;
              m_cnt_q[midx] <= m_cnt_q[midx] + COUNT_BITS'(1);
            end
            if (temp_q < m_low_q[midx])  m_low_q[midx]  <= temp_q;
            if (temp_q > m_high_q[midx]) m_high_q[midx] <= temp_q;
            if (a_cnt_q != COUNT_MAX) begin
              a_sum_q <= a_sum_q + temp_ext;
              a_cnt_q <= a_cnt_q + COUNT_BITS'(1);
            end
            if (temp_q < a_low_q)  a_low_q  <= temp_q;
            if (temp_q > a_high_q) a_high_q <= temp_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      year_q   <= in_i.year_in;
      yr_sh_q  <= in_i.year_in;
      month_q  <= in_i.month_in;
      day_q    <= in_i.day_in;
      hour_q   <= in_i.hour_in;
      minute_q <= in_i.minute_in;
      temp_q   <= in_i.temp_in;
      rmd_q    <= '0;
    end
    if (state_q == S_MOD) begin
      rmd_q   <= rmd_d;
      yr_sh_q <= {yr_sh_q[YEAR_W-2:0], 1'b0};
    end
    if (state_q == S_CHECK) begin
      err_q <= err_c;
    end
    if (state_q == S_LOAD) begin
      den_q    <= sel_cnt;
      rem_q    <= numer[NUM_W-1:Q_W];
      num_q    <= numer[Q_W-1:0];
      quo_q    <= '0;
      neg_q    <= sel_sum[SUM_W-1];
      s_cnt_q  <= sel_cnt;
      s_low_q  <= (sel_cnt == '0) ? '0 : sel_low;
      s_high_q <= (sel_cnt == '0) ? '0 : sel_high;
    end
    if (state_q == S_DIV) begin
      rem_q <= div_ge ? div_diff[COUNT_BITS-1:0] : div_t[COUNT_BITS-1:0];
      num_q <= {num_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], div_ge};
    end
    if (state_q == S_MEAN) begin
      if (phase_q) begin
        ym_q <= mean_c;
      end else begin
        mm_q   <= mean_c;
        mcnt_q <= s_cnt_q;
        mlo_q  <= s_low_q;
        mhi_q  <= s_high_q;
      end
    end
    if (out_load) begin
      accepted_q   <= (err_q == ERR_OK);
      error_code_q <= err_q;
      o_mm_q       <= mm_q;
      o_mlo_q      <= mlo_q;
      o_mhi_q      <= mhi_q;
      o_mtot_q     <= to_total(mcnt_q);
      o_ym_q       <= ym_q;
      o_ylo_q      <= s_low_q;
      o_yhi_q      <= s_high_q;
      o_ytot_q     <= to_total(s_cnt_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = accepted_q;
  assign out_o.error_code  = error_code_q;
  assign out_o.month_mean  = o_mm_q;
  assign out_o.month_min   = o_mlo_q;
  assign out_o.month_max   = o_mhi_q;
  assign out_o.month_total = o_mtot_q;
  assign out_o.year_mean   = o_ym_q;
  assign out_o.year_min    = o_ylo_q;
  assign out_o.year_max    = o_yhi_q;
  assign out_o.year_total  = o_ytot_q;

endmodule

@@ rtl/core/vtsc_checker.sv @@
// Port-level checker of the temperature statistics core, bound to the core module
`include "validated_temperature_statistics_core_macros.svh"

module vtsc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic                                 accepted_i,
  input logic [vtsc_pkg::ERR_W-1:0]           error_code_i,
  input logic signed [vtsc_pkg::MEAN_W-1:0]   year_mean_i,
  input logic signed [vtsc_pkg::TEMP_W-1:0]   year_min_i,
  input logic signed [vtsc_pkg::TEMP_W-1:0]   year_max_i,
  input logic [vtsc_pkg::TOTAL_W-1:0]         year_total_i
);
  import vtsc_pkg::*;

  `VTSC_ASSERT_IMP(a_accept_code, out_valid_i, accepted_i == (error_code_i == ERR_OK))
  `VTSC_ASSERT_IMP(a_empty_zero, out_valid_i && (year_total_i == '0),
                   (year_mean_i == '0) && (year_min_i == '0) && (year_max_i == '0))
  `VTSC_ASSERT_IMP(a_min_le_max, out_valid_i && (year_total_i != '0), year_min_i <= year_max_i)
  `VTSC_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i)
  `VTSC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(error_code_i) && $stable(year_total_i))

endmodule

bind validated_temperature_statistics_core vtsc_checker u_vtsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .accepted_i   (out_o.accepted),
  .error_code_i (out_o.error_code),
  .year_mean_i  (out_o.year_mean),
  .year_min_i   (out_o.year_min),
  .year_max_i   (out_o.year_max),
  .year_total_i (out_o.year_total)
);
